[rtl/hse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and constants for the heap sort engine and its sorting cells.
// ----------------------------------------------------------------------------
package hse_pkg;

  // width of one sorted value
  localparam int unsigned DataWidth = 32;

  // input item: one value of the set, last closes the set
  typedef struct packed {
    logic signed [DataWidth-1:0] in_value;
    logic                        in_last;
  } in_item_t;

  // result item: one value of the ascending run
  typedef struct packed {
    logic signed [DataWidth-1:0] out_value;
    logic                        out_last;
    logic                        overflow;
  } out_item_t;

  // what a cell shows to its neighbors
  typedef struct packed {
    logic                        valid;
    logic signed [DataWidth-1:0] value;
    logic                        take;
  } cell_link_t;

endpackage : hse_pkg
`default_nettype wire

[rtl/hse_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_cell
// One slot of the sorting chain. During a load the row stays in ascending
// order: a cell takes the new value where it first fits and the cells above
// it shift up by one. During a drain every cell takes its upper neighbor.
// ----------------------------------------------------------------------------
module hse_cell (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  load_i,
  input  wire                                  drain_i,
  input  wire logic signed [hse_pkg::DataWidth-1:0] new_value_i,
  input  wire hse_pkg::cell_link_t             lower_i,
  input  wire hse_pkg::cell_link_t             upper_i,
  output      hse_pkg::cell_link_t             link_o
);
  import hse_pkg::*;

  logic                        valid_q, valid_d;
  logic signed [DataWidth-1:0] value_q, value_d;
  logic                        take;

  // new value belongs at or below this slot
  assign take = !valid_q || (new_value_i < value_q);

  // next content of the slot
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (load_i) begin
      if (lower_i.take) begin
        valid_d = lower_i.valid;
        value_d = lower_i.value;
      end else if (take) begin
        valid_d = 1'b1;
        value_d = new_value_i;
      end
    end else if (drain_i) begin
      valid_d = upper_i.valid;
      value_d = upper_i.value;
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // slot data
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.value = value_q;
  assign link_o.take  = take;

endmodule : hse_cell
`default_nettype wire

[rtl/heap_sort_engine.sv]
`default_nettype none
// A transfer marked last sets busy_q; while busy_q is high, each result is
// registered from cell 0 into res_q, one result every cycle.
// Throughput: one value per cycle while loading, set by the insertion row;
// busy_o is high only while the row drains, and start_i is refused then.
// Reset clears cell occupancy, count and flags at once; no clearing pass.
// Results cannot be stalled: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// heap_sort_engine
// Sorts a set of signed values in a row of DEPTH cells and emits them in
// ascending order, flagging the greatest and each result of an overflowed set.
// ----------------------------------------------------------------------------
module heap_sort_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  wire hse_pkg::in_item_t  in_i,
  output logic                res_valid_o,
  output      hse_pkg::out_item_t res_o
);
  import hse_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            busy_q;
  logic [CntW-1:0] count_q;
  logic            dropped_q;
  logic            res_valid_q;
  out_item_t       res_q;

  logic            accept;
  logic            full;
  logic            load;

  cell_link_t      link [DEPTH];

  // input transfer and store space
  assign accept = start_i && !busy_q;
  assign full   = (count_q == CntW'(DEPTH));
  assign load   = accept && !full;

  // row of sorting cells, smallest value at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t lower;
    cell_link_t upper;

    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = link[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = link[i+1];
    end

    hse_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .drain_i     (busy_q),
      .new_value_i (in_i.in_value),
      .lower_i     (lower),
      .upper_i     (upper),
      .link_o      (link[i])
    );
  end

  // control: load counting, then draining the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= busy_q;
      if (accept) begin
        if (full) begin
          dropped_q <= 1'b1;
        end else begin
          count_q <= count_q + CntW'(1);
        end
        if (in_i.in_last) begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        count_q <= count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          busy_q    <= 1'b0;
          dropped_q <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      res_q.out_value <= link[0].value;
      res_q.out_last  <= (count_q == CntW'(1));
      res_q.overflow  <= dropped_q;
    end
  end

  assign busy_o      = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule : heap_sort_engine
`default_nettype wire
